[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros used by the checker module
// Concurrent assertion wrappers that report through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge while the active-low reset is released
`define ASSERT_RST_OFF(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/vnsl_pkg.sv]
// ----------------------------------------------------------------------------
// vnsl_pkg
// Types and fixed constants of the nearest-seed labeler.
// ----------------------------------------------------------------------------
package vnsl_pkg;

    // Fixed field widths
    localparam int SLOT_W     = 8;
    localparam int HEIGHT_W   = 9;
    localparam int LIMIT_W    = 22;
    localparam int INDEX_W    = 8;
    localparam int SEEDS_W    = 9;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 22;
    localparam int OUT_DATA_W = 40;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_SEEDS_IN_USE   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_DISTANCE_LIMIT = 1'b1;

    // Register reset values
    localparam logic [SEEDS_W-1:0] SEEDS_IN_USE_RST   = 9'd254;
    localparam logic [LIMIT_W-1:0] DISTANCE_LIMIT_RST = 22'd1000000;

    // Transaction kinds on s_tuser
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Control that travels with each seed through the distance pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } pipe_ctl_t;

endpackage

[sv/vnsl_ram.sv]
// ----------------------------------------------------------------------------
// vnsl_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module vnsl_ram #(
    parameter int WIDTH = 29,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk) begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/vnsl_dist_pipe.sv]
// ----------------------------------------------------------------------------
// vnsl_dist_pipe
// Three-stage squared-distance pipeline: absolute differences, squares, sum.
// ----------------------------------------------------------------------------
module vnsl_dist_pipe #(
    parameter int COORD_BITS = 10,
    parameter int ADDR_W     = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  vnsl_pkg::pipe_ctl_t      in_ctl,
    input  logic [ADDR_W-1:0]        in_index,
    input  logic [COORD_BITS-1:0]    in_x,
    input  logic [COORD_BITS-1:0]    in_y,
    input  logic [vnsl_pkg::HEIGHT_W-1:0] in_height,
    input  logic [COORD_BITS-1:0]    px,
    input  logic [COORD_BITS-1:0]    py,
    output vnsl_pkg::pipe_ctl_t      out_ctl,
    output logic [ADDR_W-1:0]        out_index,
    output logic [2*COORD_BITS:0]    out_dist,
    output logic [vnsl_pkg::HEIGHT_W-1:0] out_height
);

    localparam int SQ_W = 2 * COORD_BITS;

    vnsl_pkg::pipe_ctl_t ctl1_reg, ctl2_reg, ctl3_reg;
    logic [ADDR_W-1:0]   idx1_reg, idx2_reg, idx3_reg;
    logic [vnsl_pkg::HEIGHT_W-1:0] h1_reg, h2_reg, h3_reg;
    logic [COORD_BITS-1:0] dx_reg, dy_reg;
    logic [COORD_BITS-1:0] dx_next, dy_next;
    logic [SQ_W-1:0]       sqx_reg, sqy_reg;
    logic [SQ_W:0]         dist_reg;

    // Absolute coordinate differences
    always_comb begin
        dx_next = (px >= in_x) ? (px - in_x) : (in_x - px);
        dy_next = (py >= in_y) ? (py - in_y) : (in_y - py);
    end

    // Advance control through the stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end else begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    // Advance payload: differences, squares, then the sum
    always_ff @(posedge aclk) begin
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        idx1_reg <= in_index;
        h1_reg   <= in_height;

        sqx_reg  <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg  <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        idx2_reg <= idx1_reg;
        h2_reg   <= h1_reg;

        dist_reg <= (SQ_W + 1)'(sqx_reg) + (SQ_W + 1)'(sqy_reg);
        idx3_reg <= idx2_reg;
        h3_reg   <= h2_reg;
    end

    assign out_ctl    = ctl3_reg;
    assign out_index  = idx3_reg;
    assign out_dist   = dist_reg;
    assign out_height = h3_reg;

endmodule

[sv/voronoi_nearest_seed_labeler.sv]
// ----------------------------------------------------------------------------
// voronoi_nearest_seed_labeler
// Nearest-seed search over a seed table held in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: s_tuser = 0 loads a seed (slot, x, y, height) into the table;
//   s_tuser = 1 queries a pixel (x, y). A load gives no result, and s_tready
//   stays high. A query scans slots 0 to min(seeds_in_use, SEED_SLOTS)-1 and
//   returns one m_ transaction with the nearest slot, its squared distance,
//   its height and a found flag in m_tuser; ties go to the lowest slot.
//   Throughput: one seed per cycle, set by the single read port of the seed
//   memory. Each seed read passes the registered RAM read, the three distance
//   stages and the best-seed registers; the next transaction is taken once the
//   result sits in the output register.
//   s_tready is high only while no query is in progress. A finished result
//   waits in the output register while m_tready is low; a new transaction is
//   still accepted then, but a following query holds its result until the
//   output register is free.
//   cfg_we/cfg_addr/cfg_wdata write seeds_in_use (0) and distance_limit (1);
//   write them only while no query is in progress.
//   Reset (aresetn low, synchronous) restores both registers (254, 1000000)
//   and empties the output; seed table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module voronoi_nearest_seed_labeler #(
    parameter int SEED_SLOTS = 256,
    parameter int COORD_BITS = 10
) (
    input  logic aclk,
    input  logic aresetn,

    // Configuration write port
    input  logic                            cfg_we,
    input  logic [vnsl_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [vnsl_pkg::CFG_DATA_W-1:0] cfg_wdata,

    // Input stream
    input  logic s_tvalid,
    output logic s_tready,
    // s_tdata, low bit up: seed_slot, pos_x, pos_y, seed_height, zero padding
    input  logic [((vnsl_pkg::SLOT_W + 2*COORD_BITS + vnsl_pkg::HEIGHT_W + 7) / 8) * 8 - 1:0]
                 s_tdata,
    // s_tuser: func
    input  logic s_tuser,

    // Result stream
    output logic m_tvalid,
    input  logic m_tready,
    // m_tdata, low bit up: nearest_index, nearest_sq_distance, nearest_height, zero
    output logic [vnsl_pkg::OUT_DATA_W-1:0] m_tdata,
    // m_tuser: found
    output logic m_tuser
);

    localparam int ADDR_W   = $clog2(SEED_SLOTS);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int DIST_W   = 2 * COORD_BITS + 1;
    localparam int BEST_W   = (DIST_W > vnsl_pkg::LIMIT_W) ? DIST_W : vnsl_pkg::LIMIT_W;
    localparam int ENTRY_W  = 2 * COORD_BITS + vnsl_pkg::HEIGHT_W;
    localparam int X_LO     = vnsl_pkg::SLOT_W;
    localparam int Y_LO     = X_LO + COORD_BITS;
    localparam int H_LO     = Y_LO + COORD_BITS;
    localparam int OUT_PAD  = vnsl_pkg::OUT_DATA_W - vnsl_pkg::INDEX_W
                              - vnsl_pkg::LIMIT_W - vnsl_pkg::HEIGHT_W;

    // Input field views
    logic [vnsl_pkg::SLOT_W-1:0]   in_slot;
    logic [COORD_BITS-1:0]         in_x, in_y;
    logic [vnsl_pkg::HEIGHT_W-1:0] in_height;

    assign in_slot   = s_tdata[vnsl_pkg::SLOT_W-1:0];
    assign in_x      = s_tdata[Y_LO-1:X_LO];
    assign in_y      = s_tdata[H_LO-1:Y_LO];
    assign in_height = s_tdata[H_LO+vnsl_pkg::HEIGHT_W-1:H_LO];

    vnsl_pkg::state_t state_reg, state_next;

    logic [vnsl_pkg::SEEDS_W-1:0] seeds_in_use_reg;
    logic [vnsl_pkg::LIMIT_W-1:0] distance_limit_reg;
    logic [COORD_BITS-1:0]        px_reg, py_reg;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [CNT_W-1:0]             rd_addr_reg;
    vnsl_pkg::pipe_ctl_t          rd_ctl_reg, rd_ctl_next;
    logic [ADDR_W-1:0]            rd_index_reg;

    logic [BEST_W-1:0]             best_dist_reg;
    logic [ADDR_W-1:0]             best_idx_reg;
    logic [vnsl_pkg::HEIGHT_W-1:0] best_h_reg;
    logic                          hit_reg;

    logic                          m_valid_reg, m_valid_next;
    logic [vnsl_pkg::OUT_DATA_W-1:0] m_data_reg;
    logic                          m_found_reg;

    logic s_accept, is_query, load_we, issue_en, out_load, better;

    vnsl_pkg::pipe_ctl_t           pipe_ctl;
    logic [ADDR_W-1:0]             pipe_index;
    logic [DIST_W-1:0]             pipe_dist;
    logic [vnsl_pkg::HEIGHT_W-1:0] pipe_height;
    logic [ENTRY_W-1:0]            ram_rdata;

    assign s_accept = s_tvalid && s_tready;
    assign is_query = (s_tuser == vnsl_pkg::FUNC_QUERY);
    assign load_we  = s_accept && (s_tuser == vnsl_pkg::FUNC_LOAD)
                      && (int'(in_slot) < SEED_SLOTS);

    // Clamp the search count to the table size
    always_comb begin
        if (int'(seeds_in_use_reg) > SEED_SLOTS) begin
            count_next = CNT_W'(SEED_SLOTS);
        end else begin
            count_next = CNT_W'(seeds_in_use_reg);
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            vnsl_pkg::ST_IDLE: begin
                if (s_accept && is_query) begin
                    state_next = (count_next == '0) ? vnsl_pkg::ST_DONE : vnsl_pkg::ST_SCAN;
                end
            end
            vnsl_pkg::ST_SCAN: begin
                if (pipe_ctl.valid && pipe_ctl.last) begin
                    state_next = vnsl_pkg::ST_DONE;
                end
            end
            vnsl_pkg::ST_DONE: begin
                if (out_load) begin
                    state_next = vnsl_pkg::ST_IDLE;
                end
            end
            default: state_next = vnsl_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_tready = 1'b0;
        issue_en = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            vnsl_pkg::ST_IDLE: s_tready = 1'b1;
            vnsl_pkg::ST_SCAN: issue_en = (rd_addr_reg < count_reg);
            vnsl_pkg::ST_DONE: out_load = !m_valid_reg || m_tready;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vnsl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seeds_in_use_reg   <= vnsl_pkg::SEEDS_IN_USE_RST;
            distance_limit_reg <= vnsl_pkg::DISTANCE_LIMIT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                vnsl_pkg::REG_SEEDS_IN_USE:
                    seeds_in_use_reg <= cfg_wdata[vnsl_pkg::SEEDS_W-1:0];
                vnsl_pkg::REG_DISTANCE_LIMIT:
                    distance_limit_reg <= cfg_wdata;
                default: begin
                    seeds_in_use_reg <= seeds_in_use_reg;
                end
            endcase
        end
    end

    // Seed table: {height, y, x}
    vnsl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SEED_SLOTS)
    ) u_seed_ram (
        .clk   (aclk),
        .we    (load_we),
        .waddr (ADDR_W'(in_slot)),
        .wdata ({in_height, in_y, in_x}),
        .raddr (rd_addr_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Read issue control, aligned with the registered read data
    always_comb begin
        rd_ctl_next.valid = issue_en;
        rd_ctl_next.last  = issue_en && (rd_addr_reg == count_reg - CNT_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ctl_reg  <= '0;
            rd_addr_reg <= '0;
        end else begin
            rd_ctl_reg <= rd_ctl_next;
            if (s_accept && is_query) begin
                rd_addr_reg <= '0;
            end else if (issue_en) begin
                rd_addr_reg <= rd_addr_reg + CNT_W'(1);
            end
        end
    end

    // Hold query pixel and count; tag each read with its slot
    always_ff @(posedge aclk) begin
        rd_index_reg <= rd_addr_reg[ADDR_W-1:0];
        if (s_accept && is_query) begin
            px_reg    <= in_x;
            py_reg    <= in_y;
            count_reg <= count_next;
        end
    end

    vnsl_dist_pipe #(
        .COORD_BITS (COORD_BITS),
        .ADDR_W     (ADDR_W)
    ) u_dist_pipe (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_ctl     (rd_ctl_reg),
        .in_index   (rd_index_reg),
        .in_x       (ram_rdata[COORD_BITS-1:0]),
        .in_y       (ram_rdata[2*COORD_BITS-1:COORD_BITS]),
        .in_height  (ram_rdata[ENTRY_W-1:2*COORD_BITS]),
        .px         (px_reg),
        .py         (py_reg),
        .out_ctl    (pipe_ctl),
        .out_index  (pipe_index),
        .out_dist   (pipe_dist),
        .out_height (pipe_height)
    );

    // Keep the first strictly closer seed
    assign better = pipe_ctl.valid && (BEST_W'(pipe_dist) < best_dist_reg);

    always_ff @(posedge aclk) begin
        if (s_accept && is_query) begin
            best_dist_reg <= BEST_W'(distance_limit_reg);
            best_idx_reg  <= '0;
            best_h_reg    <= '0;
            hit_reg       <= 1'b0;
        end else if (better) begin
            best_dist_reg <= BEST_W'(pipe_dist);
            best_idx_reg  <= pipe_index;
            best_h_reg    <= pipe_height;
            hit_reg       <= 1'b1;
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg  <= {OUT_PAD'(0), best_h_reg,
                            vnsl_pkg::LIMIT_W'(best_dist_reg),
                            vnsl_pkg::INDEX_W'(best_idx_reg)};
            m_found_reg <= hit_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_found_reg;

endmodule

[sv/vnsl_checker.sv]
// ----------------------------------------------------------------------------
// vnsl_checker
// Port-level checks on the nearest-seed labeler, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vnsl_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [vnsl_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tuser
);

    // A stalled result stays offered
    `ASSERT_RST_OFF(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")

    // No result leaves reset
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // A miss reports slot zero and height zero
    `ASSERT_RST_OFF(a_miss_zero, aclk, aresetn, m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0 && m_tdata[38:30] == 9'd0, "miss with non-zero slot or height")

    // Padding bit stays clear
    `ASSERT_RST_OFF(a_pad_zero, aclk, aresetn, m_tvalid |-> m_tdata[39] == 1'b0, "padding bit set")

    // A load transaction on an empty output creates no result
    `ASSERT_RST_OFF(a_load_silent, aclk, aresetn, s_tvalid && s_tready && s_tuser == vnsl_pkg::FUNC_LOAD && !m_tvalid |=> !m_tvalid, "result after a load")

endmodule

bind voronoi_nearest_seed_labeler vnsl_checker u_vnsl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[tb/voronoi_nearest_seed_labeler_tb.sv]
// ----------------------------------------------------------------------------
// voronoi_nearest_seed_labeler_tb
// Self-checking bench for the nearest-seed labeler. Seeds are loaded into the
// table and pixels are queried over the input stream. A scoreboard keeps its
// own copy of the seed table and registers, works out the nearest seed for
// every accepted query and compares each result transaction field by field.
// Both stream sides idle in short random bursts, except near the end.
// ----------------------------------------------------------------------------
module voronoi_nearest_seed_labeler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEED_SLOTS    = 256;
    localparam int COORD_W       = 10;
    localparam int COORD_MAX     = (1 << COORD_W) - 1;
    localparam int HEIGHT_MAX    = 256;
    localparam int LIMIT_MAX     = 2097152;
    localparam int IN_DATA_W     = 40;
    localparam int TOTAL_ITEMS   = 1100;
    localparam int CALM_ITEMS    = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 300;
    localparam int CYCLE_LIMIT   = 2000000;

    // One nearest-seed label as carried by m_tdata and m_tuser
    typedef struct packed {
        logic [vnsl_pkg::INDEX_W-1:0]  index;
        logic                          found;
        logic [vnsl_pkg::LIMIT_W-1:0]  sq_dist;
        logic [vnsl_pkg::HEIGHT_W-1:0] height;
    } seed_label_t;

    // Scoreboard: own seed table, own registers, queue of labels still due
    class label_scoreboard;
        logic [COORD_W-1:0]            seed_x [SEED_SLOTS];
        logic [COORD_W-1:0]            seed_y [SEED_SLOTS];
        logic [vnsl_pkg::HEIGHT_W-1:0] seed_h [SEED_SLOTS];
        logic [vnsl_pkg::SEEDS_W-1:0]  seeds_in_use;
        logic [vnsl_pkg::LIMIT_W-1:0]  distance_limit;
        seed_label_t                   pending_labels[$];
        int                            errors;

        function new();
            seeds_in_use   = vnsl_pkg::SEEDS_IN_USE_RST;
            distance_limit = vnsl_pkg::DISTANCE_LIMIT_RST;
            errors         = 0;
        endfunction

        function void set_register(logic [vnsl_pkg::CFG_ADDR_W-1:0] idx,
                                   logic [vnsl_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                vnsl_pkg::REG_SEEDS_IN_USE:   seeds_in_use   = val[vnsl_pkg::SEEDS_W-1:0];
                vnsl_pkg::REG_DISTANCE_LIMIT: distance_limit = val[vnsl_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        // Store a seed, or search the table for the seed nearest to a pixel
        function void accept_item(logic func, logic [IN_DATA_W-1:0] data);
            logic [vnsl_pkg::SLOT_W-1:0]   slot;
            logic [COORD_W-1:0]            px;
            logic [COORD_W-1:0]            py;
            logic [vnsl_pkg::HEIGHT_W-1:0] h;
            int unsigned                   span;
            int unsigned                   best;
            int unsigned                   dx;
            int unsigned                   dy;
            int unsigned                   d;
            seed_label_t                   lbl;

            slot = data[vnsl_pkg::SLOT_W-1:0];
            px   = data[vnsl_pkg::SLOT_W +: COORD_W];
            py   = data[vnsl_pkg::SLOT_W+COORD_W +: COORD_W];
            h    = data[vnsl_pkg::SLOT_W+2*COORD_W +: vnsl_pkg::HEIGHT_W];
            if (func == vnsl_pkg::FUNC_LOAD) begin
                seed_x[slot] = px;
                seed_y[slot] = py;
                seed_h[slot] = h;
                return;
            end
            span        = (seeds_in_use > SEED_SLOTS) ? SEED_SLOTS : 32'(seeds_in_use);
            best        = 32'(distance_limit);
            lbl         = '0;
            lbl.sq_dist = distance_limit;
            // Only a strictly closer seed replaces the best: lowest slot wins ties
            for (int j = 0; j < span; j++) begin
                dx = 32'((px >= seed_x[j]) ? px - seed_x[j] : seed_x[j] - px);
                dy = 32'((py >= seed_y[j]) ? py - seed_y[j] : seed_y[j] - py);
                d  = dx * dx + dy * dy;
                if (d < best) begin
                    best        = d;
                    lbl.index   = vnsl_pkg::INDEX_W'(j);
                    lbl.found   = 1'b1;
                    lbl.sq_dist = vnsl_pkg::LIMIT_W'(d);
                    lbl.height  = seed_h[j];
                end
            end
            pending_labels.insert(pending_labels.size(), lbl);
        endfunction

        // Compare one result transaction with the oldest label due
        function void check_label(logic [vnsl_pkg::OUT_DATA_W-1:0] data, logic found);
            seed_label_t want;
            seed_label_t got;

            got.index   = data[vnsl_pkg::INDEX_W-1:0];
            got.sq_dist = data[vnsl_pkg::INDEX_W +: vnsl_pkg::LIMIT_W];
            got.height  = data[vnsl_pkg::INDEX_W+vnsl_pkg::LIMIT_W +: vnsl_pkg::HEIGHT_W];
            got.found   = found;
            if (pending_labels.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected label idx %0d found %0b dist %0d height %0d",
                             $realtime, got.index, got.found, got.sq_dist, got.height);
                return;
            end
            want = pending_labels.pop_front();
            if (got.index !== want.index || got.found !== want.found ||
                got.sq_dist !== want.sq_dist || got.height !== want.height) begin
                errors++;
                if (errors <= 10)
                    $display({"%0t: label error: expected idx %0d found %0b dist %0d ",
                              "height %0d, got idx %0d found %0b dist %0d height %0d"},
                             $realtime, want.index, want.found, want.sq_dist, want.height,
                             got.index, got.found, got.sq_dist, got.height);
            end
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_we;
    logic [vnsl_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [vnsl_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [IN_DATA_W-1:0]            s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [vnsl_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            m_tuser;

    label_scoreboard sb = new();
    int              items_sent = 0;
    int              cycles = 0;
    int              stall_left = 0;
    bit              gaps_on = 1'b1;
    bit              stalls_on = 1'b1;
    bit              calm = 1'b0;

    voronoi_nearest_seed_labeler uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Abort a run that hangs
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("voronoi_nearest_seed_labeler: mismatch");
            $finish;
        end
    end

    // Check each result transaction, then stall the result side in short bursts
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_label(m_tdata, m_tuser);
        if (stall_left == 0 && stalls_on && !calm && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 3);
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Drop valid and pause the sender
    task automatic pause_sender(input int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Offer one transaction and wait for the handshake
    task automatic send_item(input logic func, input int slot, input int x, input int y,
                             input int h);
        logic [IN_DATA_W-1:0] data;

        data = IN_DATA_W'({vnsl_pkg::HEIGHT_W'(h), COORD_W'(y), COORD_W'(x),
                           vnsl_pkg::SLOT_W'(slot)});
        if (gaps_on && !calm && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 3));
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= func;
        do @(posedge aclk); while (!s_tready);
        sb.accept_item(func, data);
        items_sent++;
    endtask

    // Hold the sender until every label due has arrived and the block is free
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending_labels.size() != 0 || !s_tready);
    endtask

    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write both registers back to back while the block is idle
    task automatic configure(input int seeds, input int limit);
        cfg_we    <= 1'b1;
        cfg_addr  <= vnsl_pkg::REG_SEEDS_IN_USE;
        cfg_wdata <= vnsl_pkg::CFG_DATA_W'(seeds);
        @(posedge aclk);
        cfg_addr  <= vnsl_pkg::REG_DISTANCE_LIMIT;
        cfg_wdata <= vnsl_pkg::CFG_DATA_W'(limit);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_register(vnsl_pkg::REG_SEEDS_IN_USE, vnsl_pkg::CFG_DATA_W'(seeds));
        sb.set_register(vnsl_pkg::REG_DISTANCE_LIMIT, vnsl_pkg::CFG_DATA_W'(limit));
    endtask

    task automatic query_pixel(input int x, input int y);
        send_item(vnsl_pkg::FUNC_QUERY, $urandom_range(0, 255), x, y,
                  $urandom_range(0, HEIGHT_MAX));
    endtask

    task automatic load_random_seed(input int slot);
        send_item(vnsl_pkg::FUNC_LOAD, slot, $urandom_range(0, COORD_MAX),
                  $urandom_range(0, COORD_MAX), $urandom_range(0, HEIGHT_MAX));
    endtask

    initial begin
        int phase_len;
        int r;
        int k;
        int px;
        int py;
        int span;
        int seeds;
        int limit;

        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = vnsl_pkg::REG_SEEDS_IN_USE;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = vnsl_pkg::FUNC_LOAD;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // No seeds searched: nothing found
        configure(0, int'(vnsl_pkg::DISTANCE_LIMIT_RST));
        query_pixel(300, 400);

        // Corner seeds, a duplicate of slot 0 and a centre seed
        send_item(vnsl_pkg::FUNC_LOAD, 0, 0, 0, 0);
        send_item(vnsl_pkg::FUNC_LOAD, 1, COORD_MAX, COORD_MAX, HEIGHT_MAX);
        send_item(vnsl_pkg::FUNC_LOAD, 2, COORD_MAX, 0, 255);
        send_item(vnsl_pkg::FUNC_LOAD, 3, 0, COORD_MAX, 1);
        send_item(vnsl_pkg::FUNC_LOAD, 4, 0, 0, 170);
        send_item(vnsl_pkg::FUNC_LOAD, 5, 512, 512, 85);
        settle();
        configure(6, LIMIT_MAX);
        query_pixel(0, 0);
        query_pixel(COORD_MAX, COORD_MAX);
        query_pixel(COORD_MAX, 0);
        query_pixel(0, COORD_MAX);
        query_pixel(256, 256);
        query_pixel(512, 512);

        // Limit of zero rejects even an exact hit; limit of one admits only it
        settle();
        configure(6, 0);
        query_pixel(0, 0);
        settle();
        configure(1, 1);
        query_pixel(0, 0);
        query_pixel(1, 0);

        // Fill every slot so that any search count is safe from here on
        settle();
        configure(int'(vnsl_pkg::SEEDS_IN_USE_RST), int'(vnsl_pkg::DISTANCE_LIMIT_RST));
        for (int s = 0; s < SEED_SLOTS; s++)
            load_random_seed(s);
        settle();
        configure(SEED_SLOTS, int'(vnsl_pkg::DISTANCE_LIMIT_RST));
        query_pixel($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        query_pixel($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        settle();
        configure(511, LIMIT_MAX);
        query_pixel($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        query_pixel(0, COORD_MAX);

        // Random phases, each with its own register setting
        while (items_sent < TOTAL_ITEMS) begin
            settle();
            r = $urandom_range(0, 99);
            if (r < 8)
                seeds = 0;
            else if (r < 65)
                seeds = $urandom_range(1, 32);
            else if (r < 88)
                seeds = $urandom_range(33, 255);
            else if (r < 96)
                seeds = SEED_SLOTS;
            else
                seeds = $urandom_range(SEED_SLOTS + 1, 511);
            r = $urandom_range(0, 99);
            if (r < 10)
                limit = 0;
            else if (r < 25)
                limit = LIMIT_MAX;
            else if (r < 40)
                limit = int'(vnsl_pkg::DISTANCE_LIMIT_RST);
            else if (r < 75)
                limit = $urandom_range(0, 50000);
            else
                limit = $urandom_range(0, LIMIT_MAX);
            configure(seeds, limit);
            span      = (seeds > SEED_SLOTS) ? SEED_SLOTS : seeds;
            phase_len = $urandom_range(20, 80);
            gaps_on   = $urandom_range(0, 2) != 0;
            stalls_on = $urandom_range(0, 2) != 0;
            for (int i = 0; i < phase_len && items_sent < TOTAL_ITEMS; i++) begin
                if (items_sent >= TOTAL_ITEMS - CALM_ITEMS)
                    calm = 1'b1;
                if (!calm && $urandom_range(0, 59) == 0)
                    hold_until_drained();
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    load_random_seed($urandom_range(0, SEED_SLOTS - 1));
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 40 && span > 0) begin
                        // Close to a searched seed, possibly right on it
                        k  = $urandom_range(0, span - 1);
                        px = int'(sb.seed_x[k]) + int'($urandom_range(0, 6)) - 3;
                        py = int'(sb.seed_y[k]) + int'($urandom_range(0, 6)) - 3;
                        px = (px < 0) ? 0 : (px > COORD_MAX) ? COORD_MAX : px;
                        py = (py < 0) ? 0 : (py > COORD_MAX) ? COORD_MAX : py;
                    end else if (r < 55) begin
                        px = $urandom_range(0, 1) ? COORD_MAX : 0;
                        py = $urandom_range(0, 1) ? COORD_MAX : 0;
                    end else begin
                        px = $urandom_range(0, COORD_MAX);
                        py = $urandom_range(0, COORD_MAX);
                    end
                    query_pixel(px, py);
                end
            end
        end

        // Let the last labels arrive, then give the block time to go quiet
        calm = 1'b1;
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_labels.size() == 0) begin
            $display("voronoi_nearest_seed_labeler: match");
        end else begin
            $display("voronoi_nearest_seed_labeler: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/vnsl_pkg.sv
sv/vnsl_ram.sv
sv/vnsl_dist_pipe.sv
sv/voronoi_nearest_seed_labeler.sv
sv/vnsl_checker.sv
tb/voronoi_nearest_seed_labeler_tb.sv
